// ===== rtl/core/rfp_pkg.sv =====
package rfp_pkg;

   localparam int HEADER_BYTES_DEF = 4;
   localparam int FIFO_DEPTH = 4;

   localparam int WORD_W = 32;
   localparam int LEN_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAGIC_FIRST  = 3'd0,
      CSR_MAGIC_SECOND = 3'd1,
      CSR_VERSION_CODE = 3'd2,
      CSR_BEGIN_CODE   = 3'd3,
      CSR_DATA_CODE    = 3'd4,
      CSR_COMMIT_CODE  = 3'd5,
      CSR_ABORT_CODE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] magic_first;
      logic [7:0] magic_second;
      logic [7:0] version_code;
      logic [7:0] begin_code;
      logic [7:0] data_code;
      logic [7:0] commit_code;
      logic [7:0] abort_code;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        payload_byte;
      logic              frame_ok;
      logic [7:0]        command_value;
      logic [WORD_W-1:0] total_size;
      logic [WORD_W-1:0] expected_crc;
      logic [WORD_W-1:0] transfer_number;
      logic [WORD_W-1:0] chunk_offset;
      logic [LEN_W-1:0]  payload_length;
      logic              run_end;
   } result_type;

   // up to two results leave one accepted byte
   typedef struct packed {
      logic       push_first;
      logic       push_second;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== rtl/core/rfp_parse.sv =====
module rfp_parse #(
   parameter int HEADER_BYTES = rfp_pkg::HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rfp_pkg::cfg_type    cfg,
   input  logic                beat_en,
   input  logic [7:0]          frame_byte,
   input  logic                final_byte,
   output rfp_pkg::push_type   push
);

   typedef enum logic [2:0] {
      CMD_OTHER,
      CMD_BEGIN,
      CMD_DATA,
      CMD_COMMIT,
      CMD_ABORT
   } cmd_type;

   localparam logic [15:0] POS_HDR      = 16'(HEADER_BYTES);
   localparam logic [15:0] POS_HDR_LAST = 16'(HEADER_BYTES - 1);
   localparam logic [15:0] POS_SHORT_OK = 16'(HEADER_BYTES + 3);
   localparam logic [15:0] POS_LONG_OK  = 16'(HEADER_BYTES + 7);

   logic [15:0]                 byte_position_ff, byte_position_in;
   logic                        header_good_ff, header_good_in;
   logic [7:0]                  held_command_ff, held_command_in;
   logic [rfp_pkg::WORD_W-1:0]  first_word_ff, first_word_in;
   logic [rfp_pkg::WORD_W-1:0]  second_word_ff, second_word_in;
   logic [rfp_pkg::LEN_W-1:0]   payload_counter_ff, payload_counter_in;

   logic [15:0]                 body_index;
   logic                        in_body;
   logic                        payload_hit;
   logic                        hdr_done;
   logic                        frame_ok;
   cmd_type                     cmd_kind;
   rfp_pkg::result_type         payload_res;
   rfp_pkg::result_type         verdict_res;

   function automatic cmd_type classify(input logic [7:0] c, input rfp_pkg::cfg_type r);
      cmd_type k;
      if (c == r.begin_code) k = CMD_BEGIN;
      else if (c == r.data_code) k = CMD_DATA;
      else if (c == r.commit_code) k = CMD_COMMIT;
      else if (c == r.abort_code) k = CMD_ABORT;
      else k = CMD_OTHER;
      return k;
   endfunction

   always_comb begin
      header_good_in  = header_good_ff;
      held_command_in = held_command_ff;
      first_word_in   = first_word_ff;
      second_word_in  = second_word_ff;
      payload_counter_in = payload_counter_ff;

      case (byte_position_ff)
         16'd0:   if (frame_byte != cfg.magic_first) header_good_in = 1'b0;
         16'd1:   if (frame_byte != cfg.magic_second) header_good_in = 1'b0;
         16'd2:   if (frame_byte != cfg.version_code) header_good_in = 1'b0;
         16'd3:   held_command_in = frame_byte;
         default: ;
      endcase

      cmd_kind   = classify(held_command_in, cfg);
      in_body    = byte_position_ff >= POS_HDR;
      body_index = byte_position_ff - POS_HDR;
      payload_hit = 1'b0;

      if (in_body) begin
         if (body_index < 16'd4) begin
            first_word_in = {first_word_ff[rfp_pkg::WORD_W-9:0], frame_byte};
         end else if (body_index < 16'd8) begin
            second_word_in = {second_word_ff[rfp_pkg::WORD_W-9:0], frame_byte};
         end else if (header_good_in && cmd_kind == CMD_DATA) begin
            payload_hit = 1'b1;
            if (payload_counter_ff != '1) payload_counter_in = payload_counter_ff + 1'b1;
         end
      end

      // verdict from the state as updated by this byte
      hdr_done = header_good_in && byte_position_ff >= POS_HDR_LAST;
      case (cmd_kind)
         CMD_BEGIN, CMD_DATA:   frame_ok = hdr_done && byte_position_ff >= POS_LONG_OK;
         CMD_COMMIT, CMD_ABORT: frame_ok = hdr_done && byte_position_ff >= POS_SHORT_OK;
         default:               frame_ok = hdr_done;
      endcase

      payload_res = '0;
      payload_res.payload_byte = frame_byte;
      payload_res.run_end = ~final_byte;

      verdict_res = '0;
      verdict_res.kind = 1'b1;
      verdict_res.frame_ok = frame_ok;
      verdict_res.run_end = 1'b1;
      if (hdr_done) verdict_res.command_value = held_command_in;
      if (frame_ok) begin
         case (cmd_kind)
            CMD_BEGIN: begin
               verdict_res.total_size   = first_word_in;
               verdict_res.expected_crc = second_word_in;
            end
            CMD_DATA: begin
               verdict_res.transfer_number = first_word_in;
               verdict_res.chunk_offset    = second_word_in;
               verdict_res.payload_length  = payload_counter_in;
            end
            CMD_COMMIT, CMD_ABORT: begin
               verdict_res.transfer_number = first_word_in;
            end
            default: ;
         endcase
      end

      push.push_first  = beat_en && (payload_hit || final_byte);
      push.push_second = beat_en && payload_hit && final_byte;
      push.first  = payload_hit ? payload_res : verdict_res;
      push.second = verdict_res;

      if (final_byte) begin
         byte_position_in   = '0;
         header_good_in     = 1'b1;
         held_command_in    = '0;
         first_word_in      = '0;
         second_word_in     = '0;
         payload_counter_in = '0;
      end else if (byte_position_ff != '1) begin
         byte_position_in = byte_position_ff + 1'b1;
      end else begin
         byte_position_in = byte_position_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= '0;
         header_good_ff     <= 1'b1;
         held_command_ff    <= '0;
         first_word_ff      <= '0;
         second_word_ff     <= '0;
         payload_counter_ff <= '0;
      end else if (beat_en) begin
         byte_position_ff   <= byte_position_in;
         header_good_ff     <= header_good_in;
         held_command_ff    <= held_command_in;
         first_word_ff      <= first_word_in;
         second_word_ff     <= second_word_in;
         payload_counter_ff <= payload_counter_in;
      end
   end

endmodule

// ===== rtl/core/rfp_rsp_fifo.sv =====
module rfp_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  rfp_pkg::push_type    push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rfp_pkg::result_type  out_res
);

   localparam int DEPTH = rfp_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rfp_pkg::result_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pop;
   logic [PTR_W-1:0]      wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != '0;
   assign out_res   = entry_ff[rd_ptr_ff];
   // two free entries, so a byte that gives two results always fits
   assign room      = count_ff <= CNT_W'(DEPTH - 2);
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.push_first) + PTR_W'(push.push_second);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.push_first) + CNT_W'(push.push_second)
                  - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_first) entry_ff[wr_ptr_ff] <= push.first;
      if (push.push_second) entry_ff[wr_next] <= push.second;
   end

endmodule

// ===== rtl/core/request_frame_parser_unit.sv =====
// a result is offered in the cycle after its byte is accepted, if the queue was empty
// throughput: one byte per cycle; a payload byte that also ends the frame
// queues two results, which leave one per cycle while rsp_tready is high, from a four-entry queue;
// the input stalls only while three or more results wait
// reset: synchronous; configuration registers go to zero, the queue empties
// and the frame state returns to its start, with the header flag set
module request_frame_parser_unit #(
   parameter int HEADER_BYTES = rfp_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // frame_byte
   input  logic                              req_tlast,   // final_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // payload_byte, frame_ok, command_value, total_size, expected_crc,
   // transfer_number, chunk_offset, payload_length, zero fill
   output logic [167:0]                      rsp_tdata,
   output logic                              rsp_tuser,   // kind
   output logic                              rsp_tlast,   // run_end
   input  logic                              csr_wr_en,
   input  logic [rfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfp_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   rfp_pkg::cfg_type     cfg_ff, cfg_in;
   rfp_pkg::push_type    push;
   rfp_pkg::result_type  out_res;
   logic                 room;
   logic                 beat_en;

   assign req_tready = room;
   assign beat_en    = req_tvalid && room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rfp_pkg::CSR_MAGIC_FIRST:  cfg_in.magic_first  = csr_wr_data;
            rfp_pkg::CSR_MAGIC_SECOND: cfg_in.magic_second = csr_wr_data;
            rfp_pkg::CSR_VERSION_CODE: cfg_in.version_code = csr_wr_data;
            rfp_pkg::CSR_BEGIN_CODE:   cfg_in.begin_code   = csr_wr_data;
            rfp_pkg::CSR_DATA_CODE:    cfg_in.data_code    = csr_wr_data;
            rfp_pkg::CSR_COMMIT_CODE:  cfg_in.commit_code  = csr_wr_data;
            rfp_pkg::CSR_ABORT_CODE:   cfg_in.abort_code   = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfp_parse #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .beat_en    (beat_en),
      .frame_byte (req_tdata),
      .final_byte (req_tlast),
      .push       (push)
   );

   rfp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.run_end;
   assign rsp_tdata = {7'd0,
                       out_res.payload_length,
                       out_res.chunk_offset,
                       out_res.transfer_number,
                       out_res.expected_crc,
                       out_res.total_size,
                       out_res.command_value,
                       out_res.frame_ok,
                       out_res.payload_byte};

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   localparam int HDR_LEN          = rfp_pkg::HEADER_BYTES_DEF;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT      = 3000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int RANDOM_BYTES     = 1650;
   localparam int RANDOM_PHASES    = 5;
   localparam logic [rfp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef enum int {CLS_OTHER, CLS_BEGIN, CLS_DATA, CLS_COMMIT, CLS_ABORT} cmd_class_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [167:0]                    rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_wr_en = 1'b0;
   logic [rfp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rfp_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   request_frame_parser_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // configuration and frame state as the parser should hold them
   rfp_pkg::cfg_type cfg_shadow = '0;
   logic [15:0] frame_pos = '0;
   logic        frame_hdr_good = 1'b1;
   logic [7:0]  frame_cmd = '0;
   logic [31:0] word_a = '0;
   logic [31:0] word_b = '0;
   logic [15:0] pay_count = '0;

   rfp_pkg::result_type awaited_results[$];
   logic [7:0]  frame_buf[$];
   rfp_pkg::result_type want_result;
   rfp_pkg::result_type got_result;

   int fail_count = 0;
   int sent_bytes = 0;
   int verdict_count = 0;
   int ok_count = 0;
   int payload_count = 0;
   int config_count = 0;
   int stall_cycles = 0;
   int hold_off_asked = 0;
   int hold_off_served = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;

   function automatic cmd_class_type class_of(input logic [7:0] c);
      if (c == cfg_shadow.begin_code) return CLS_BEGIN;
      if (c == cfg_shadow.data_code) return CLS_DATA;
      if (c == cfg_shadow.commit_code) return CLS_COMMIT;
      if (c == cfg_shadow.abort_code) return CLS_ABORT;
      return CLS_OTHER;
   endfunction

   // works out the results one accepted byte causes
   function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
      rfp_pkg::result_type r;
      int unsigned   p;
      int unsigned   body;
      cmd_class_type k;
      bit            hdr_ok;
      bit            ok;
      p = {16'd0, frame_pos};
      if (p == 0) begin
         if (b != cfg_shadow.magic_first) frame_hdr_good = 1'b0;
      end else if (p == 1) begin
         if (b != cfg_shadow.magic_second) frame_hdr_good = 1'b0;
      end else if (p == 2) begin
         if (b != cfg_shadow.version_code) frame_hdr_good = 1'b0;
      end else if (p == 3) begin
         frame_cmd = b;
      end
      k = class_of(frame_cmd);
      if (p >= HDR_LEN) begin
         if (p - HDR_LEN < 4) begin
            word_a = {word_a[23:0], b};
         end else if (p - HDR_LEN < 8) begin
            word_b = {word_b[23:0], b};
         end else if (frame_hdr_good && k == CLS_DATA) begin
            r = '0;
            r.payload_byte = b;
            r.run_end = !last;
            awaited_results.push_back(r);
            if (pay_count != 16'hFFFF) pay_count++;
         end
      end
      if (last) begin
         r = '0;
         r.kind = 1'b1;
         r.run_end = 1'b1;
         hdr_ok = frame_hdr_good && (p + 1 >= HDR_LEN);
         body = hdr_ok ? p + 1 - HDR_LEN : 0;
         ok = 1'b0;
         if (hdr_ok) begin
            r.command_value = frame_cmd;
            case (k)
               CLS_BEGIN, CLS_DATA:   ok = (body >= 8);
               CLS_COMMIT, CLS_ABORT: ok = (body >= 4);
               default:               ok = 1'b1;
            endcase
         end
         if (ok) begin
            case (k)
               CLS_BEGIN: begin
                  r.total_size = word_a;
                  r.expected_crc = word_b;
               end
               CLS_DATA: begin
                  r.transfer_number = word_a;
                  r.chunk_offset = word_b;
                  r.payload_length = pay_count;
               end
               CLS_COMMIT, CLS_ABORT: begin
                  r.transfer_number = word_a;
               end
               default: ;
            endcase
         end
         r.frame_ok = ok;
         awaited_results.push_back(r);
         frame_pos = '0;
         frame_hdr_good = 1'b1;
         frame_cmd = '0;
         word_a = '0;
         word_b = '0;
         pay_count = '0;
      end else if (frame_pos != 16'hFFFF) begin
         frame_pos++;
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // result checking, byte prediction and progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_result.kind            = rsp_tuser;
            got_result.payload_byte    = rsp_tdata[7:0];
            got_result.frame_ok        = rsp_tdata[8];
            got_result.command_value   = rsp_tdata[16:9];
            got_result.total_size      = rsp_tdata[48:17];
            got_result.expected_crc    = rsp_tdata[80:49];
            got_result.transfer_number = rsp_tdata[112:81];
            got_result.chunk_offset    = rsp_tdata[144:113];
            got_result.payload_length  = rsp_tdata[160:145];
            got_result.run_end         = rsp_tlast;
            if (awaited_results.size() == 0) begin
               $display("%0t unexpected beat: expected none, actual kind %0b data %0h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want_result = awaited_results.pop_front();
               check_field("kind", 32'(want_result.kind), 32'(got_result.kind));
               check_field("payload_byte", 32'(want_result.payload_byte),
                           32'(got_result.payload_byte));
               check_field("frame_ok", 32'(want_result.frame_ok), 32'(got_result.frame_ok));
               check_field("command_value", 32'(want_result.command_value),
                           32'(got_result.command_value));
               check_field("total_size", want_result.total_size, got_result.total_size);
               check_field("expected_crc", want_result.expected_crc, got_result.expected_crc);
               check_field("transfer_number", want_result.transfer_number,
                           got_result.transfer_number);
               check_field("chunk_offset", want_result.chunk_offset, got_result.chunk_offset);
               check_field("payload_length", 32'(want_result.payload_length),
                           32'(got_result.payload_length));
               check_field("run_end", 32'(want_result.run_end), 32'(got_result.run_end));
               if (want_result.kind) begin
                  verdict_count++;
                  if (want_result.frame_ok) ok_count++;
               end else begin
                  payload_count++;
               end
            end
         end
         if (req_tvalid && req_tready) parse_frame_byte(req_tdata, req_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_wr_en) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t no beat moved for %0d cycles, %0d results outstanding",
                        $time, stall_cycles, awaited_results.size());
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // result side: random gap after each beat, long hold-off on request
   initial begin : rsp_side
      int gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) gap_left = rsp_gaps_on ? $urandom_range(0, 6) : 0;
         if (hold_off_asked != hold_off_served) begin
            hold_off_served++;
            gap_left = LONG_HOLD_CYCLES;
         end
         if (gap_left > 0) begin
            rsp_tready <= 1'b0;
            gap_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frame_buf.delete();
   endtask

   function automatic void add_header(input logic [7:0] cmd);
      frame_buf.push_back(cfg_shadow.magic_first);
      frame_buf.push_back(cfg_shadow.magic_second);
      frame_buf.push_back(cfg_shadow.version_code);
      frame_buf.push_back(cmd);
   endfunction

   function automatic void add_word(input logic [31:0] w);
      frame_buf.push_back(w[31:24]);
      frame_buf.push_back(w[23:16]);
      frame_buf.push_back(w[15:8]);
      frame_buf.push_back(w[7:0]);
   endfunction

   // sender stops until every awaited result is in and the block has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      // let the checker record the last accepted byte first
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      case (idx)
         rfp_pkg::CSR_MAGIC_FIRST:  cfg_shadow.magic_first = val;
         rfp_pkg::CSR_MAGIC_SECOND: cfg_shadow.magic_second = val;
         rfp_pkg::CSR_VERSION_CODE: cfg_shadow.version_code = val;
         rfp_pkg::CSR_BEGIN_CODE:   cfg_shadow.begin_code = val;
         rfp_pkg::CSR_DATA_CODE:    cfg_shadow.data_code = val;
         rfp_pkg::CSR_COMMIT_CODE:  cfg_shadow.commit_code = val;
         rfp_pkg::CSR_ABORT_CODE:   cfg_shadow.abort_code = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input rfp_pkg::cfg_type c, input bit poke_unused);
      csr_write(rfp_pkg::CSR_MAGIC_FIRST, c.magic_first);
      csr_write(rfp_pkg::CSR_MAGIC_SECOND, c.magic_second);
      csr_write(rfp_pkg::CSR_VERSION_CODE, c.version_code);
      csr_write(rfp_pkg::CSR_BEGIN_CODE, c.begin_code);
      csr_write(rfp_pkg::CSR_DATA_CODE, c.data_code);
      csr_write(rfp_pkg::CSR_COMMIT_CODE, c.commit_code);
      csr_write(rfp_pkg::CSR_ABORT_CODE, c.abort_code);
      if (poke_unused) csr_write(CSR_UNUSED_INDEX, 8'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      config_count++;
   endtask

   function automatic rfp_pkg::cfg_type random_config();
      rfp_pkg::cfg_type c;
      c.magic_first  = 8'($urandom);
      c.magic_second = 8'($urandom);
      c.version_code = 8'($urandom);
      // offsets keep the four codes apart
      c.begin_code   = 8'($urandom);
      c.data_code    = c.begin_code + 8'($urandom_range(1, 63));
      c.commit_code  = c.data_code + 8'($urandom_range(1, 63));
      c.abort_code   = c.commit_code + 8'($urandom_range(1, 63));
      return c;
   endfunction

   function automatic rfp_pkg::cfg_type fixed_config();
      rfp_pkg::cfg_type c;
      c.magic_first  = 8'hA5;
      c.magic_second = 8'h5A;
      c.version_code = 8'h01;
      c.begin_code   = 8'h10;
      c.data_code    = 8'h20;
      c.commit_code  = 8'h30;
      c.abort_code   = 8'h40;
      return c;
   endfunction

   task automatic test_directed_frames();
      apply_config(fixed_config(), 1'b0);
      // frames that end inside the header
      frame_buf.push_back(8'hA5);
      send_frame();
      frame_buf = '{8'hA5, 8'h5A, 8'h01};
      send_frame();
      // unknown command with no body
      add_header(8'h77);
      send_frame();
      // begin with extreme words
      add_header(cfg_shadow.begin_code);
      add_word(32'hFFFF_FFFF);
      add_word(32'h0000_0000);
      send_frame();
      // data whose last byte is payload
      add_header(cfg_shadow.data_code);
      add_word(32'h1234_5678);
      add_word(32'h9ABC_DEF0);
      frame_buf.push_back(8'h00);
      frame_buf.push_back(8'hFF);
      send_frame();
      // commit with trailing bytes
      add_header(cfg_shadow.commit_code);
      add_word(32'h8000_0001);
      frame_buf.push_back(8'hEE);
      frame_buf.push_back(8'h11);
      send_frame();
      // abort and data with short bodies
      add_header(cfg_shadow.abort_code);
      frame_buf.push_back(8'h01);
      frame_buf.push_back(8'h02);
      frame_buf.push_back(8'h03);
      send_frame();
      add_header(cfg_shadow.data_code);
      add_word(32'h0000_00FF);
      frame_buf.push_back(8'h7F);
      send_frame();
      // bad second magic on a data frame: no payload may leave
      add_header(cfg_shadow.data_code);
      frame_buf[1] = 8'h00;
      add_word(32'h0102_0304);
      add_word(32'h0506_0708);
      frame_buf.push_back(8'h80);
      frame_buf.push_back(8'h81);
      send_frame();
      // bad version on a begin frame
      add_header(cfg_shadow.begin_code);
      frame_buf[2] = 8'h02;
      add_word(32'hDEAD_BEEF);
      add_word(32'hCAFE_F00D);
      send_frame();
      wait_idle();
   endtask

   task automatic test_equal_codes();
      rfp_pkg::cfg_type c;
      c = fixed_config();
      c.begin_code = 8'h33;
      c.data_code = 8'h33;
      c.commit_code = 8'h33;
      c.abort_code = 8'h33;
      apply_config(c, 1'b1);
      add_header(8'h33);
      add_word(32'h0000_0010);
      add_word(32'h0000_0020);
      frame_buf.push_back(8'h55);
      send_frame();
      wait_idle();
      // data shares its code with commit and abort and must win
      c.begin_code = 8'h10;
      c.data_code = 8'h44;
      c.commit_code = 8'h44;
      c.abort_code = 8'h44;
      apply_config(c, 1'b1);
      add_header(8'h44);
      add_word(32'hA0A0_A0A0);
      add_word(32'h0505_0505);
      frame_buf.push_back(8'h99);
      send_frame();
      wait_idle();
   endtask

   task automatic test_backpressure();
      int n;
      int i;
      apply_config(fixed_config(), 1'b0);
      hold_off_asked++;
      for (n = 0; n < 3; n++) begin
         add_header(cfg_shadow.data_code);
         add_word(32'($urandom));
         add_word(32'($urandom));
         for (i = 0; i < 20; i++) frame_buf.push_back(8'($urandom));
         send_frame();
      end
      wait_idle();
      add_header(cfg_shadow.commit_code);
      add_word(32'($urandom));
      send_frame();
      wait_idle();
   endtask

   task automatic send_random_frame();
      int         pick;
      int         body_len;
      int         i;
      int         cut;
      logic [7:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise
         body_len = $urandom_range(1, 6);
         for (i = 0; i < body_len; i++) frame_buf.push_back(8'($urandom));
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: cmd = cfg_shadow.data_code;
            3, 4:    cmd = cfg_shadow.begin_code;
            5:       cmd = cfg_shadow.commit_code;
            6:       cmd = cfg_shadow.abort_code;
            default: cmd = 8'($urandom);
         endcase
         add_header(cmd);
         if (pick < 20) begin
            i = $urandom_range(0, 2);
            frame_buf[i] = frame_buf[i] ^ 8'($urandom_range(1, 255));
         end
         body_len = (cmd == cfg_shadow.data_code) ? $urandom_range(0, 30)
                                                  : $urandom_range(0, 12);
         for (i = 0; i < body_len; i++) frame_buf.push_back(8'($urandom));
         if (pick >= 95) begin
            cut = $urandom_range(1, HDR_LEN - 1);
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
         end
      end
      send_frame();
   endtask

   task automatic test_random_phases();
      rfp_pkg::cfg_type c;
      int      phase;
      int      start;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1:       c = '0;
            2:       c = '1;
            default: c = random_config();
         endcase
         apply_config(c, phase == 0);
         req_gaps_on = (phase != 3);
         rsp_gaps_on = (phase != 3) && (phase != 4);
         start = sent_bytes;
         while (sent_bytes - start < RANDOM_BYTES / RANDOM_PHASES) send_random_frame();
         wait_idle();
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_equal_codes();
      test_backpressure();
      test_random_phases();
      repeat (10) @(posedge clock);
      $display("sent %0d bytes under %0d register settings", sent_bytes, config_count);
      $display("checked %0d verdicts (%0d ok) and %0d payload beats",
               verdict_count, ok_count, payload_count);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count,
                  awaited_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
